// ===== rtl/bmpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpt_pkg
// Shared types, widths and codes of the biased mark position table unit.
// ----------------------------------------------------------------------------
package bmpt_pkg;

   localparam int SLOTS  = 32;
   localparam int SLOT_W = 5;
   localparam int CNT_W  = 6;
   localparam int GEN_W  = 16;
   localparam int POS_W  = 32;

   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [GEN_W-1:0] GEN_MAX   = {GEN_W{1'b1}};

   // operation codes of an input item
   localparam logic [2:0] FN_ADD   = 3'd0;
   localparam logic [2:0] FN_DEL   = 3'd1;
   localparam logic [2:0] FN_QRY   = 3'd2;
   localparam logic [2:0] FN_REP   = 3'd3;
   localparam logic [2:0] FN_LIST  = 3'd4;
   localparam logic [2:0] FN_EINS  = 3'd5;
   localparam logic [2:0] FN_EDEL  = 3'd6;
   localparam logic [2:0] FN_BAD   = 3'd7;

   // result status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_DEAD  = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_OVF   = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;
   localparam logic [2:0] ST_FUNC  = 3'd5;

   // datapath step codes
   localparam logic [4:0] OP_NONE    = 5'd0;
   localparam logic [4:0] OP_LOAD    = 5'd1;
   localparam logic [4:0] OP_STEP    = 5'd2;
   localparam logic [4:0] OP_ALLOC   = 5'd3;
   localparam logic [4:0] OP_AT      = 5'd4;
   localparam logic [4:0] OP_SHUP    = 5'd5;
   localparam logic [4:0] OP_PLACE   = 5'd6;
   localparam logic [4:0] OP_SHDN    = 5'd7;
   localparam logic [4:0] OP_SHRINK  = 5'd8;
   localparam logic [4:0] OP_FREE    = 5'd9;
   localparam logic [4:0] OP_REPOS   = 5'd10;
   localparam logic [4:0] OP_FIRST   = 5'd11;
   localparam logic [4:0] OP_OVCHK   = 5'd12;
   localparam logic [4:0] OP_RGSTART = 5'd13;
   localparam logic [4:0] OP_RGSTEP  = 5'd14;
   localparam logic [4:0] OP_COPY    = 5'd15;
   localparam logic [4:0] OP_MVSTART = 5'd16;
   localparam logic [4:0] OP_MVSTEP  = 5'd17;
   localparam logic [4:0] OP_DLSTEP  = 5'd18;
   localparam logic [4:0] OP_EMIT    = 5'd19;
   localparam logic [4:0] OP_LIST    = 5'd20;
   localparam logic [4:0] OP_FLUSH   = 5'd21;

   typedef struct packed {
      logic [2:0]       func;
      logic [4:0]       mark_id;
      logic [15:0]      mark_gen;
      logic [31:0]      position;
      logic             bias;
      logic [31:0]      edit_length;
      logic [31:0]      range_end;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [4:0]       out_id;
      logic [15:0]      out_gen;
      logic [31:0]      out_position;
      logic             found;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [4:0]       op;
      logic             scan;
      logic [2:0]       code;
      logic             slot_rsp;
   } cmd_type;

   typedef struct packed {
      logic [2:0]       func;
      logic             handle_ok;
      logic             scan_end;
      logic             pos_gt_p;
      logic             pos_ge_p;
      logic             gt_rend;
      logic             lt_rend;
      logic             scan_bias;
      logic             scan_is_cur;
      logic             scan_ovf;
      logic             shift_done;
      logic             remove_last;
      logic             alloc_free;
      logic             alloc_new;
      logic             copy_done;
      logic             at_eq_end;
      logic             rsp_free;
      logic             pend_valid;
      logic             range_bad;
      logic             len_zero;
      logic             del_ovf;
   } stat_type;

endpackage

// ===== rtl/biased_mark_position_table_unit.sv =====
// ----------------------------------------------------------------------------
// biased_mark_position_table_unit
// Table of up to 32 text marks kept sorted by position.
//
// An item enters on req_valid/req_ready and carries one operation: add,
// delete, query, reposition, range listing, edit insert or edit delete.
// Results leave on rsp_valid/rsp_ready; every item gives one result except
// a range listing with a valid range, which gives one per listed mark, the
// final one with last, or one empty result with last if none is listed.
// One item is worked on at a time and the order-list walk sets the rate:
// each pass takes one entry a cycle, except that a listing waits out every
// cycle in which a stalled receiver holds its previous result.
// Reset empties the table at once; no clearing pass is needed.
// The result sits in an output register; while the receiver stalls the next
// item is still taken, and its own result waits until that register frees.
// ----------------------------------------------------------------------------
module biased_mark_position_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmpt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bmpt_pkg::rsp_type rsp_payload
);

   bmpt_pkg::cmd_type  cmd;
   bmpt_pkg::stat_type stat;

   // sequencer
   bmpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and result register
   bmpt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ===== rtl/bmpt_dp.sv =====
// ----------------------------------------------------------------------------
// bmpt_dp
// Mark storage, order list, walk counters and result register.
// ----------------------------------------------------------------------------
module bmpt_dp (
   input  logic               clock,
   input  logic               reset,
   input  bmpt_pkg::req_type  req_payload,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output bmpt_pkg::rsp_type  rsp_payload,
   input  bmpt_pkg::cmd_type  cmd,
   output bmpt_pkg::stat_type stat
);

   localparam int SW = bmpt_pkg::SLOT_W;
   localparam int CW = bmpt_pkg::CNT_W;
   localparam int GW = bmpt_pkg::GEN_W;
   localparam int PW = bmpt_pkg::POS_W;

   // storage
   logic [PW-1:0]          pos_ff   [bmpt_pkg::SLOTS];
   logic                   bias_ff  [bmpt_pkg::SLOTS];
   logic [GW-1:0]          gen_ff   [bmpt_pkg::SLOTS];
   logic [CW-1:0]          nf_ff    [bmpt_pkg::SLOTS];
   logic [SW-1:0]          order_ff [bmpt_pkg::SLOTS];
   logic [SW-1:0]          tmp_ff   [bmpt_pkg::SLOTS];
   logic [bmpt_pkg::SLOTS-1:0] live_ff, live_in;

   logic [CW-1:0] used_ff, used_in, free_head_ff, free_head_in, count_ff, count_in;
   bmpt_pkg::req_type req_ff, req_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic [CW-1:0] idx_ff, idx_in, mark_ff, mark_in, wr_ff, wr_in;
   logic [CW-1:0] tcnt_ff, tcnt_in, tj_ff, tj_in, eq_end_ff, eq_end_in;
   logic          eq_set_ff, eq_set_in;
   bmpt_pkg::rsp_type pend_ff, pend_in, rsp_ff, rsp_in;
   logic          pend_valid_ff, pend_valid_in, rsp_valid_ff, rsp_valid_in;

   // write ports
   logic          pos_we, bias_we, gen_we, nf_we, ord_we, tmp_we;
   logic [SW-1:0] pos_wa, gen_wa, nf_wa, ord_wa, tmp_wa;
   logic [PW-1:0] pos_in;
   logic          bias_in;
   logic [GW-1:0] gen_in;
   logic [CW-1:0] nf_in;
   logic [SW-1:0] ord_in, tmp_in;
   logic          rsp_load;

   // read side
   logic [CW-1:0] ord_ra_w;
   logic [SW-1:0] ord_ra, order_rd, slot_ra, alloc_slot;
   logic [PW-1:0] sp;
   logic          sb, sl;
   logic [GW-1:0] sg;
   logic [PW:0]   end_sum;
   logic          moves;

   // one order read and one slot read per cycle
   always_comb begin
      unique case (cmd.op)
         bmpt_pkg::OP_SHUP: ord_ra_w = wr_ff - CW'(1);
         bmpt_pkg::OP_SHDN: ord_ra_w = idx_ff + CW'(1);
         default:           ord_ra_w = idx_ff;
      endcase
      ord_ra   = ord_ra_w[SW-1:0];
      order_rd = order_ff[ord_ra];
      slot_ra  = cmd.scan ? order_rd : cur_ff;
      sp       = pos_ff[slot_ra];
      sb       = bias_ff[slot_ra];
      sg       = gen_ff[slot_ra];
      sl       = live_ff[slot_ra];
      end_sum  = {1'b0, req_ff.position} + {1'b0, req_ff.edit_length};
      moves    = (sp > req_ff.position) || sb;
   end

   // status towards the controller
   always_comb begin
      stat.func        = req_ff.func;
      stat.handle_ok   = ({1'b0, req_ff.mark_id} < used_ff) && sl
                         && (sg == req_ff.mark_gen[GW-1:0]);
      stat.scan_end    = idx_ff == count_ff;
      stat.pos_gt_p    = sp > req_ff.position;
      stat.pos_ge_p    = sp >= req_ff.position;
      stat.gt_rend     = sp > req_ff.range_end;
      stat.lt_rend     = sp < req_ff.range_end;
      stat.scan_bias   = sb;
      stat.scan_is_cur = order_rd == cur_ff;
      stat.scan_ovf    = moves && (sp > ~req_ff.edit_length);
      stat.shift_done  = wr_ff == mark_ff;
      stat.remove_last = ({1'b0, idx_ff} + (CW+1)'(1)) >= {1'b0, count_ff};
      stat.alloc_free  = free_head_ff < bmpt_pkg::SLOTS_CNT;
      stat.alloc_new   = used_ff < bmpt_pkg::SLOTS_CNT;
      stat.copy_done   = tj_ff == tcnt_ff;
      stat.at_eq_end   = idx_ff == eq_end_ff;
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
      stat.pend_valid  = pend_valid_ff;
      stat.range_bad   = req_ff.position > req_ff.range_end;
      stat.len_zero    = req_ff.edit_length == '0;
      stat.del_ovf     = req_ff.edit_length > ~req_ff.position;
   end

   assign alloc_slot = (free_head_ff < bmpt_pkg::SLOTS_CNT) ? free_head_ff[SW-1:0]
                                                            : used_ff[SW-1:0];

   // step execution
   always_comb begin
      req_in        = req_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      mark_in       = mark_ff;
      wr_in         = wr_ff;
      tcnt_in       = tcnt_ff;
      tj_in         = tj_ff;
      eq_end_in     = eq_end_ff;
      eq_set_in     = eq_set_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_load      = 1'b0;
      used_in       = used_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      live_in       = live_ff;
      pos_we = 1'b0; pos_wa = slot_ra; pos_in = req_ff.position;
      bias_we = 1'b0; bias_in = req_ff.bias;
      gen_we = 1'b0; gen_wa = cur_ff; gen_in = GW'(1);
      nf_we = 1'b0; nf_wa = cur_ff; nf_in = bmpt_pkg::SLOTS_CNT;
      ord_we = 1'b0; ord_wa = wr_ff[SW-1:0]; ord_in = order_rd;
      tmp_we = 1'b0; tmp_wa = tcnt_ff[SW-1:0]; tmp_in = order_rd;
      unique case (cmd.op)
         bmpt_pkg::OP_LOAD: begin
            req_in        = req_payload;
            cur_in        = req_payload.mark_id;
            idx_in        = '0;
            tcnt_in       = '0;
            tj_in         = '0;
            eq_set_in     = 1'b0;
            pend_valid_in = 1'b0;
         end
         bmpt_pkg::OP_STEP: idx_in = idx_ff + CW'(1);
         bmpt_pkg::OP_ALLOC: begin
            if (free_head_ff < bmpt_pkg::SLOTS_CNT) begin
               free_head_in = nf_ff[alloc_slot];
            end else begin
               used_in = used_ff + CW'(1);
               gen_we  = 1'b1;
               gen_wa  = alloc_slot;
            end
            pos_we  = 1'b1;
            pos_wa  = alloc_slot;
            bias_we = 1'b1;
            live_in[alloc_slot] = 1'b1;
            nf_we   = 1'b1;
            nf_wa   = alloc_slot;
            cur_in  = alloc_slot;
            idx_in  = '0;
         end
         bmpt_pkg::OP_AT: begin
            mark_in = idx_ff;
            wr_in   = count_ff;
         end
         bmpt_pkg::OP_SHUP: begin
            ord_we = 1'b1;
            wr_in  = wr_ff - CW'(1);
         end
         bmpt_pkg::OP_PLACE: begin
            ord_we   = 1'b1;
            ord_wa   = mark_ff[SW-1:0];
            ord_in   = cur_ff;
            count_in = count_ff + CW'(1);
         end
         bmpt_pkg::OP_SHDN: begin
            ord_we = 1'b1;
            ord_wa = idx_ff[SW-1:0];
            idx_in = idx_ff + CW'(1);
         end
         bmpt_pkg::OP_SHRINK: count_in = count_ff - CW'(1);
         bmpt_pkg::OP_FREE: begin
            live_in[cur_ff] = 1'b0;
            nf_we = 1'b1;
            if (sg != bmpt_pkg::GEN_MAX) begin
               gen_we       = 1'b1;
               gen_in       = sg + GW'(1);
               nf_in        = free_head_ff;
               free_head_in = {1'b0, cur_ff};
            end
         end
         bmpt_pkg::OP_REPOS: begin
            pos_we = 1'b1;
            pos_wa = cur_ff;
            idx_in = '0;
         end
         bmpt_pkg::OP_FIRST: begin
            mark_in = idx_ff;
            wr_in   = idx_ff;
         end
         bmpt_pkg::OP_OVCHK: begin
            if (!eq_set_ff && (sp > req_ff.position)) begin
               eq_end_in = idx_ff;
               eq_set_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
         end
         bmpt_pkg::OP_RGSTART: begin
            idx_in = mark_ff;
            if (!eq_set_ff) eq_end_in = count_ff;
         end
         bmpt_pkg::OP_RGSTEP: begin
            if (!sb) begin
               ord_we = 1'b1;
               wr_in  = wr_ff + CW'(1);
            end else begin
               tmp_we  = 1'b1;
               tcnt_in = tcnt_ff + CW'(1);
            end
            idx_in = idx_ff + CW'(1);
         end
         bmpt_pkg::OP_COPY: begin
            ord_we = 1'b1;
            ord_in = tmp_ff[tj_ff[SW-1:0]];
            wr_in  = wr_ff + CW'(1);
            tj_in  = tj_ff + CW'(1);
         end
         bmpt_pkg::OP_MVSTART: idx_in = mark_ff;
         bmpt_pkg::OP_MVSTEP: begin
            pos_we = moves;
            pos_in = sp + req_ff.edit_length;
            idx_in = idx_ff + CW'(1);
         end
         bmpt_pkg::OP_DLSTEP: begin
            pos_we = 1'b1;
            pos_in = ({1'b0, sp} < end_sum) ? req_ff.position : sp - req_ff.edit_length;
            idx_in = idx_ff + CW'(1);
         end
         bmpt_pkg::OP_EMIT: begin
            rsp_load = 1'b1;
            rsp_in.status       = cmd.code;
            rsp_in.out_id       = cmd.slot_rsp ? cur_ff : '0;
            rsp_in.out_gen      = cmd.slot_rsp ? sg : '0;
            rsp_in.out_position = cmd.slot_rsp ? sp : '0;
            rsp_in.found        = cmd.slot_rsp;
            rsp_in.last         = 1'b1;
         end
         bmpt_pkg::OP_LIST: begin
            pend_in.status       = bmpt_pkg::ST_OK;
            pend_in.out_id       = order_rd;
            pend_in.out_gen      = sg;
            pend_in.out_position = sp - req_ff.position;
            pend_in.found        = 1'b1;
            pend_in.last         = 1'b0;
            pend_valid_in        = 1'b1;
            if (pend_valid_ff) begin
               rsp_load = 1'b1;
               rsp_in   = pend_ff;
            end
            idx_in = idx_ff + CW'(1);
         end
         bmpt_pkg::OP_FLUSH: begin
            rsp_load = 1'b1;
            if (pend_valid_ff) begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end else begin
               rsp_in = '{status: bmpt_pkg::ST_OK, out_id: '0, out_gen: '0,
                          out_position: '0, found: 1'b0, last: 1'b1};
            end
            pend_valid_in = 1'b0;
         end
         default: ;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff       <= '0;
         used_ff       <= '0;
         free_head_ff  <= bmpt_pkg::SLOTS_CNT;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         live_ff       <= live_in;
         used_ff       <= used_in;
         free_head_ff  <= free_head_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers and tables
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      mark_ff   <= mark_in;
      wr_ff     <= wr_in;
      tcnt_ff   <= tcnt_in;
      tj_ff     <= tj_in;
      eq_end_ff <= eq_end_in;
      eq_set_ff <= eq_set_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
      if (pos_we)  pos_ff[pos_wa]    <= pos_in;
      if (bias_we) bias_ff[pos_wa]   <= bias_in;
      if (gen_we)  gen_ff[gen_wa]    <= gen_in;
      if (nf_we)   nf_ff[nf_wa]      <= nf_in;
      if (ord_we)  order_ff[ord_wa]  <= ord_in;
      if (tmp_we)  tmp_ff[tmp_wa]    <= tmp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/bmpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmpt_ctrl
// Sequencer that walks the order list one entry a cycle for the operations that need a walk.
// ----------------------------------------------------------------------------
module bmpt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bmpt_pkg::stat_type stat,
   output bmpt_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_INS   = 4'd2;
   localparam logic [3:0] S_SHUP  = 4'd3;
   localparam logic [3:0] S_RMF   = 4'd4;
   localparam logic [3:0] S_RMS   = 4'd5;
   localparam logic [3:0] S_FREE  = 4'd6;
   localparam logic [3:0] S_REPOS = 4'd7;
   localparam logic [3:0] S_LB    = 4'd8;
   localparam logic [3:0] S_LIST  = 4'd9;
   localparam logic [3:0] S_FLUSH = 4'd10;
   localparam logic [3:0] S_OVC   = 4'd11;
   localparam logic [3:0] S_RG    = 4'd12;
   localparam logic [3:0] S_CP    = 4'd13;
   localparam logic [3:0] S_WALK  = 4'd14;
   localparam logic [3:0] S_EMIT  = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [2:0] code_ff, code_in;
   logic       slot_ff, slot_in;
   logic [3:0] after_rm;

   assign after_rm = (stat.func == bmpt_pkg::FN_DEL) ? S_FREE : S_REPOS;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      slot_in      = slot_ff;
      cmd.op       = bmpt_pkg::OP_NONE;
      cmd.scan     = 1'b0;
      cmd.code     = code_ff;
      cmd.slot_rsp = slot_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = bmpt_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         // decode the item and run the checks that need no walk
         S_DISP: begin
            code_in  = bmpt_pkg::ST_OK;
            slot_in  = 1'b0;
            state_in = S_EMIT;
            unique case (stat.func)
               bmpt_pkg::FN_ADD: begin
                  if (stat.alloc_free || stat.alloc_new) begin
                     cmd.op   = bmpt_pkg::OP_ALLOC;
                     state_in = S_INS;
                  end else begin
                     code_in = bmpt_pkg::ST_FULL;
                  end
               end
               bmpt_pkg::FN_DEL, bmpt_pkg::FN_REP: begin
                  if (stat.handle_ok) state_in = S_RMF;
                  else code_in = bmpt_pkg::ST_DEAD;
               end
               bmpt_pkg::FN_QRY: begin
                  if (stat.handle_ok) slot_in = 1'b1;
                  else code_in = bmpt_pkg::ST_DEAD;
               end
               bmpt_pkg::FN_LIST: begin
                  if (stat.range_bad) code_in = bmpt_pkg::ST_RANGE;
                  else state_in = S_LB;
               end
               bmpt_pkg::FN_EINS: begin
                  if (!stat.len_zero) state_in = S_LB;
               end
               bmpt_pkg::FN_EDEL: begin
                  if (stat.del_ovf && !stat.len_zero) code_in = bmpt_pkg::ST_OVF;
                  else if (!stat.len_zero) state_in = S_LB;
               end
               default: code_in = bmpt_pkg::ST_FUNC;
            endcase
         end
         // find the slot after the marks at the same position
         S_INS: begin
            cmd.scan = 1'b1;
            if (stat.scan_end || stat.pos_gt_p) begin
               cmd.op   = bmpt_pkg::OP_AT;
               state_in = S_SHUP;
            end else begin
               cmd.op = bmpt_pkg::OP_STEP;
            end
         end
         S_SHUP: begin
            if (stat.shift_done) begin
               cmd.op   = bmpt_pkg::OP_PLACE;
               code_in  = bmpt_pkg::ST_OK;
               slot_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.op = bmpt_pkg::OP_SHUP;
            end
         end
         // take the mark out of the order list
         S_RMF: begin
            cmd.scan = 1'b1;
            if (stat.scan_end) state_in = after_rm;
            else if (stat.scan_is_cur) state_in = S_RMS;
            else cmd.op = bmpt_pkg::OP_STEP;
         end
         S_RMS: begin
            if (stat.remove_last) begin
               cmd.op   = bmpt_pkg::OP_SHRINK;
               state_in = after_rm;
            end else begin
               cmd.op = bmpt_pkg::OP_SHDN;
            end
         end
         S_FREE: begin
            cmd.op   = bmpt_pkg::OP_FREE;
            state_in = S_EMIT;
         end
         S_REPOS: begin
            cmd.op   = bmpt_pkg::OP_REPOS;
            state_in = S_INS;
         end
         // first entry at or after the position
         S_LB: begin
            cmd.scan = 1'b1;
            if (stat.scan_end || stat.pos_ge_p) begin
               cmd.op = bmpt_pkg::OP_FIRST;
               unique case (stat.func)
                  bmpt_pkg::FN_LIST: state_in = S_LIST;
                  bmpt_pkg::FN_EINS: state_in = S_OVC;
                  default:           state_in = S_WALK;
               endcase
            end else begin
               cmd.op = bmpt_pkg::OP_STEP;
            end
         end
         // listing holds one item back to know which is last
         S_LIST: begin
            cmd.scan = 1'b1;
            if (stat.scan_end || stat.gt_rend) begin
               state_in = S_FLUSH;
            end else if (stat.lt_rend || !stat.scan_bias) begin
               if (!stat.pend_valid || stat.rsp_free) cmd.op = bmpt_pkg::OP_LIST;
            end else begin
               cmd.op = bmpt_pkg::OP_STEP;
            end
         end
         S_FLUSH: begin
            if (stat.rsp_free) begin
               cmd.op   = bmpt_pkg::OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         // insertion: overflow check, regroup, copy right-bias, move
         S_OVC: begin
            cmd.scan = 1'b1;
            if (stat.scan_end) begin
               cmd.op   = bmpt_pkg::OP_RGSTART;
               state_in = S_RG;
            end else if (stat.scan_ovf) begin
               code_in  = bmpt_pkg::ST_OVF;
               state_in = S_EMIT;
            end else begin
               cmd.op = bmpt_pkg::OP_OVCHK;
            end
         end
         S_RG: begin
            cmd.scan = 1'b1;
            if (stat.at_eq_end) state_in = S_CP;
            else cmd.op = bmpt_pkg::OP_RGSTEP;
         end
         S_CP: begin
            if (stat.copy_done) begin
               cmd.op   = bmpt_pkg::OP_MVSTART;
               state_in = S_WALK;
            end else begin
               cmd.op = bmpt_pkg::OP_COPY;
            end
         end
         // shift positions of the tail for either edit
         S_WALK: begin
            cmd.scan = 1'b1;
            if (stat.scan_end) begin
               state_in = S_EMIT;
            end else if (stat.func == bmpt_pkg::FN_EINS) begin
               cmd.op = bmpt_pkg::OP_MVSTEP;
            end else begin
               cmd.op = bmpt_pkg::OP_DLSTEP;
            end
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.op   = bmpt_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= bmpt_pkg::ST_OK;
         slot_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         slot_ff  <= slot_in;
      end
   end

endmodule
